// ===== src/rrts_pkg.sv =====
package rrts_pkg;

  localparam int JOIN_W = 4;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_EXIT   = 2'd1,
    CMD_JOIN   = 2'd2,
    CMD_YIELD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    SCAN_CREATE,
    SCAN_PICK,
    SCAN_WAKE
  } scan_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JOIN_RD,
    S_JOIN_CHK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [JOIN_W-1:0] join_slot;
    slot_state_t       st;
  } slot_entry_t;

  typedef struct packed {
    logic        we;
    logic        hit;
    slot_entry_t wentry;
  } eval_result_t;

endpackage

// ===== src/rrts_slot_mem.sv =====
module rrts_slot_mem #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  rrts_pkg::slot_entry_t      wdata,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  output rrts_pkg::slot_entry_t      rdata
);
  import rrts_pkg::*;

  localparam int IW = $clog2(SLOTS);

  slot_entry_t          mem [SLOTS];
  logic [SLOTS-1:0]     vld;
  slot_entry_t          rd_q;
  logic                 rd_vld;
  logic [IW-1:0]        rd_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= raddr;
    if (we && (waddr == raddr)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[raddr] || (we && (waddr == raddr));
    end
  end

  // Slots never written read as their reset value: slot 0 running, the rest dead.
  always_comb begin
    if (rd_vld) begin
      rdata = rd_q;
    end else begin
      rdata.join_slot = '0;
      rdata.st        = (rd_addr == '0) ? ST_RUNNING : ST_DEAD;
    end
  end

endmodule

// ===== src/rrts_slot_eval.sv =====
module rrts_slot_eval #(
  parameter int IDX_W = 4
) (
  input  logic                   valid,
  input  rrts_pkg::scan_mode_t   mode,
  input  rrts_pkg::slot_entry_t  entry,
  input  logic [IDX_W-1:0]       cur,
  input  logic                   found,
  output rrts_pkg::eval_result_t res
);
  import rrts_pkg::*;

  localparam int CW = (IDX_W > JOIN_W) ? IDX_W : JOIN_W;

  logic wake;

  assign wake = (entry.st == ST_BLOCKED) && (CW'(entry.join_slot) == CW'(cur));

  always_comb begin
    res.we               = 1'b0;
    res.hit              = 1'b0;
    res.wentry.join_slot = entry.join_slot;
    res.wentry.st        = ST_RUNNABLE;
    unique case (mode)
      SCAN_CREATE: begin
        res.hit = valid && !found && (entry.st == ST_DEAD);
        res.we  = res.hit;
      end
      SCAN_PICK: begin
        res.hit = valid && !found && (entry.st == ST_RUNNABLE);
      end
      SCAN_WAKE: begin
        res.we  = valid && wake;
        res.hit = valid && !found && (wake || (entry.st == ST_RUNNABLE));
      end
      default: begin
        res.we  = 1'b0;
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/round_robin_thread_scheduler_unit.sv =====
// Round-robin thread scheduler over a table of THREAD_SLOTS slots, one command per
// transfer. The slot table sits in a single-port-read, single-port-write memory, and
// one compare unit looks at one slot per cycle: create scans from slot 0 for the
// lowest dead slot, while exit, yield and a blocking join scan the other slots in
// round-robin order after the running one, waking slots blocked on an exiting thread
// in the same pass. A create, yield or join scan stops on its first hit, while an exit
// scans every other slot to wake the blocked ones; a join first reads its target, and
// a join on a dead or missing slot finishes without a scan. The block takes no new
// command until the result of the current one has been loaded into the output
// register.
module round_robin_thread_scheduler_unit #(
  parameter int THREAD_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrts_pkg::cmd_t     command,
  input  logic [3:0]         target_thread,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [3:0]         new_thread,
  output logic [3:0]         running_thread
);
  import rrts_pkg::*;

  localparam int IW = $clog2(THREAD_SLOTS);
  localparam int RW = $clog2(THREAD_SLOTS + 1);

  state_t         state;
  state_t         state_next;
  cmd_t           cmd_q;
  logic [3:0]     target_q;
  logic [IW-1:0]  cur;
  logic [IW-1:0]  idx;
  logic [RW-1:0]  remaining;
  logic           inflight;
  logic [IW-1:0]  inflight_idx;
  logic           found;
  logic [IW-1:0]  chosen;
  logic           pick;
  scan_mode_t     mode;

  logic           accept;
  logic           issue;
  logic           target_live;
  logic           finish_load;
  logic [IW-1:0]  final_slot;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  slot_entry_t    mem_wdata;
  logic [IW-1:0]  mem_raddr;
  slot_entry_t    mem_rdata;
  eval_result_t   ev;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == IW'(THREAD_SLOTS - 1)) ? '0 : v + 1'b1;
  endfunction

  rrts_slot_mem #(
    .SLOTS(THREAD_SLOTS)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rrts_slot_eval #(
    .IDX_W(IW)
  ) u_eval (
    .valid(inflight && (state == S_SCAN)),
    .mode (mode),
    .entry(mem_rdata),
    .cur  (cur),
    .found(found),
    .res  (ev)
  );

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign target_live = (32'(target_q) < THREAD_SLOTS) && (mem_rdata.st != ST_DEAD);
  assign finish_load = (state == S_FINISH) && (!out_valid || !out_stall);
  assign final_slot  = (pick && found) ? chosen : cur;
  assign issue       = (remaining != '0) &&
                       !((mode != SCAN_WAKE) && (found || ev.hit));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_JOIN) ? S_JOIN_RD : S_SCAN;
        end
      end
      S_JOIN_RD: begin
        state_next = S_JOIN_CHK;
      end
      S_JOIN_CHK: begin
        state_next = target_live ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (!issue) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we              = 1'b0;
    mem_waddr           = cur;
    mem_wdata.join_slot = '0;
    mem_wdata.st        = ST_RUNNING;
    mem_raddr           = idx;
    unique case (state)
      S_IDLE: begin
        if (accept && (command == CMD_EXIT)) begin
          mem_we       = 1'b1;
          mem_wdata.st = ST_DEAD;
        end else if (accept && (command == CMD_YIELD)) begin
          mem_we       = 1'b1;
          mem_wdata.st = ST_RUNNABLE;
        end
      end
      S_JOIN_RD: begin
        mem_raddr = IW'(target_q);
      end
      S_JOIN_CHK: begin
        if (target_live) begin
          mem_we              = 1'b1;
          mem_wdata.join_slot = target_q;
          mem_wdata.st        = ST_BLOCKED;
        end
      end
      S_SCAN: begin
        mem_we    = ev.we;
        mem_waddr = inflight_idx;
        mem_wdata = ev.wentry;
      end
      S_FINISH: begin
        mem_we    = finish_load && pick;
        mem_waddr = final_slot;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      inflight  <= 1'b0;
      found     <= 1'b0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cmd_q    <= command;
        target_q <= target_thread;
        found    <= 1'b0;
        inflight <= 1'b0;
        pick     <= (command != CMD_CREATE);
        if (command == CMD_CREATE) begin
          idx       <= '0;
          remaining <= RW'(THREAD_SLOTS);
          mode      <= SCAN_CREATE;
        end else begin
          idx       <= wrap_inc(cur);
          remaining <= RW'(THREAD_SLOTS - 1);
          mode      <= (command == CMD_EXIT) ? SCAN_WAKE : SCAN_PICK;
        end
      end
      if ((state == S_JOIN_CHK) && !target_live) begin
        pick <= 1'b0;
      end
      if (state == S_SCAN) begin
        if (ev.hit) begin
          found  <= 1'b1;
          chosen <= inflight_idx;
        end
        inflight <= issue;
        if (issue) begin
          inflight_idx <= idx;
          idx          <= wrap_inc(idx);
          remaining    <= remaining - 1'b1;
        end
      end
      if (finish_load) begin
        out_valid      <= 1'b1;
        status         <= (cmd_q == CMD_CREATE) && !found;
        new_thread     <= ((cmd_q == CMD_CREATE) && found) ? 4'(chosen) : 4'd0;
        running_thread <= 4'(final_slot);
        cur            <= final_slot;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
